[rtl/core/h4df_pkg.sv]
// Shared types and codes for the HCI H4 UART deframer.
package h4df_pkg;

    // H4 packet type bytes
    localparam logic [7:0] TYPE_ACL   = 8'h02;
    localparam logic [7:0] TYPE_SCO   = 8'h03;
    localparam logic [7:0] TYPE_EVENT = 8'h04;

    // Packet kind held while a packet is parsed
    localparam logic [1:0] PKT_NONE  = 2'd0;
    localparam logic [1:0] PKT_EVENT = 2'd1;
    localparam logic [1:0] PKT_ACL   = 2'd2;
    localparam logic [1:0] PKT_SCO   = 2'd3;

    // Header sizes after the type byte
    localparam logic [2:0] HDR_LEN_EVENT = 3'd2;
    localparam logic [2:0] HDR_LEN_ACL   = 3'd4;
    localparam logic [2:0] HDR_LEN_SCO   = 3'd3;

    // Output kind codes
    localparam logic [2:0] KIND_TYPE   = 3'd0;
    localparam logic [2:0] KIND_EVENT  = 3'd1;
    localparam logic [2:0] KIND_ACL    = 3'd2;
    localparam logic [2:0] KIND_SCO    = 3'd3;
    localparam logic [2:0] KIND_VENDOR = 3'd4;

    // End status codes
    localparam logic [1:0] END_NONE    = 2'd0;
    localparam logic [1:0] END_OK      = 2'd1;
    localparam logic [1:0] END_DROP    = 2'd2;
    localparam logic [1:0] END_SCO_OFF = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCO_DELIVER     = 8'd1;

    localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd1024;

    typedef struct packed {
        logic [15:0] max_payload_len;
        logic        sco_deliver;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  out_kind;
        logic        in_header;
        logic [1:0]  end_status;
        logic [15:0] payload_len;
    } t_result;

endpackage

[rtl/core/h4df_parser.sv]
// H4 packet parser: per-byte state update and tagging of each byte.
module h4df_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  h4df_pkg::t_cfg    i_cfg,
    output h4df_pkg::t_result o_res
);
    import h4df_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_HDR  = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_kind, n_kind;
    logic [2:0]  r_hidx, n_hidx;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_left, n_left;

    logic [2:0]  w_hsize;
    logic [2:0]  w_hidx_inc;
    logic [1:0]  w_good_end;
    t_result     w_res;

    always_comb begin
        unique case (r_kind)
            PKT_EVENT: w_hsize = HDR_LEN_EVENT;
            PKT_ACL:   w_hsize = HDR_LEN_ACL;
            default:   w_hsize = HDR_LEN_SCO;
        endcase
    end

    assign w_hidx_inc = r_hidx + 3'd1;
    assign w_good_end = (r_kind == PKT_SCO && !i_cfg.sco_deliver) ? END_SCO_OFF : END_OK;

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_hidx  = r_hidx;
        n_low   = r_low;
        n_left  = r_left;

        w_res.out_byte    = i_byte;
        w_res.out_kind    = KIND_VENDOR;
        w_res.in_header   = 1'b0;
        w_res.end_status  = END_NONE;
        w_res.payload_len = 16'd0;

        unique case (r_phase)
            PH_HDR: begin
                w_res.out_kind  = {1'b0, r_kind};
                w_res.in_header = 1'b1;
                // low length byte sits just before the last header byte
                if (r_hidx == w_hsize - 3'd2) begin
                    n_low = i_byte;
                end
                n_hidx = w_hidx_inc;
                if (w_hidx_inc >= w_hsize) begin
                    if (r_kind == PKT_ACL) begin
                        w_res.payload_len = {i_byte, n_low};
                    end else begin
                        w_res.payload_len = {8'd0, i_byte};
                    end
                    n_hidx = 3'd0;
                    if (w_res.payload_len == 16'd0) begin
                        w_res.end_status = w_good_end;
                        n_phase = PH_TYPE;
                    end else if (w_res.payload_len > i_cfg.max_payload_len) begin
                        // drop and hunt for the next type byte
                        w_res.end_status = END_DROP;
                        n_phase = PH_TYPE;
                    end else begin
                        n_left  = w_res.payload_len;
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                w_res.out_kind = {1'b0, r_kind};
                n_left = r_left - 16'd1;
                if (n_left == 16'd0) begin
                    w_res.end_status = w_good_end;
                    n_phase = PH_TYPE;
                end
            end
            default: begin
                n_phase = PH_TYPE;
                if (i_byte == TYPE_EVENT || i_byte == TYPE_ACL || i_byte == TYPE_SCO) begin
                    w_res.out_kind = KIND_TYPE;
                    n_kind  = (i_byte == TYPE_EVENT) ? PKT_EVENT :
                              (i_byte == TYPE_ACL)   ? PKT_ACL   : PKT_SCO;
                    n_hidx  = 3'd0;
                    n_low   = 8'd0;
                    n_phase = PH_HDR;
                end
            end
        endcase
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_kind  <= PKT_NONE;
            r_hidx  <= 3'd0;
            r_low   <= 8'd0;
            r_left  <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_hidx  <= n_hidx;
            r_low   <= n_low;
            r_left  <= n_left;
        end
    end

    a_data_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != 16'd0)
        else $error("payload phase with no bytes left");

    a_hdr_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HDR |-> r_hidx < w_hsize)
        else $error("header index past header size");

    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR || r_phase == PH_DATA) |-> r_kind != PKT_NONE)
        else $error("packet phase without packet kind");

endmodule

[rtl/core/hci_h4_uart_deframer.sv]
// HCI H4 UART deframer: one received byte in, one tagged byte out, one item per cycle
// while the output is not stalled, through the input register, the parser update and
// the result register. Header bytes carry the decoded payload length on their last
// byte, and the last byte of a packet carries its end status. Configuration writes are
// taken at any time and are meant to be issued only while no item is in flight.
module hci_h4_uart_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [h4df_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // tagged byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [9:8] end_status,
                                        // [25:10] payload_len, [31:26] zero
    output logic [3:0]  m_axis_tuser    // [2:0] out_kind, [3] in_header
);
    import h4df_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_payload_len <= MAX_PAYLOAD_LEN_RST;
            r_cfg.sco_deliver     <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MAX_PAYLOAD_LEN) begin
                r_cfg.max_payload_len <= i_cfg_data;
            end else if (i_cfg_index == REG_SCO_DELIVER) begin
                r_cfg.sco_deliver <= i_cfg_data[0];
            end
        end
    end

    // advance when the result register is free or being drained
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    h4df_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.payload_len, r_out.end_status, r_out.out_byte};
    assign m_axis_tuser  = {r_out.in_header, r_out.out_kind};

    a_hdr_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.in_header |->
            (r_out.out_kind == KIND_EVENT || r_out.out_kind == KIND_ACL ||
             r_out.out_kind == KIND_SCO))
        else $error("header byte tagged with non-packet kind");

    a_len_on_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.payload_len != 16'd0 |-> r_out.in_header)
        else $error("payload length outside the header");

    a_drop_on_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.end_status == END_DROP |->
            r_out.in_header && r_out.payload_len > r_cfg.max_payload_len)
        else $error("drop status without oversize header");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid)
        else $error("result lost while stalled");

endmodule

[bench/hci_h4_uart_deframer_chk.sv]
// Scoreboard for the H4 deframer: predicts every tagged byte and checks the output stream.
module hci_h4_uart_deframer_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [h4df_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [31:0]                    i_m_tdata,
    input  logic [3:0]                     i_m_tuser,
    output int                             o_mismatches,
    output int                             o_pending
);
    import h4df_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT_TYPE,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_cfg        cfg;
    t_phase      phase;
    logic [1:0]  pkt;
    logic [2:0]  hdr_idx;
    logic [7:0]  len_lo;
    logic [15:0] bytes_left;

    t_result tagged_byte_q[$];
    int      mismatch_count = 0;
    int      result_no      = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                 $time, result_no, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [1:0] good_end();
        return (pkt == PKT_SCO && !cfg.sco_deliver) ? END_SCO_OFF : END_OK;
    endfunction

    // Advance the parser by one received byte and return its tagged form.
    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result     r;
        logic [2:0]  hsize;
        logic [15:0] len;
        r.out_byte    = b;
        r.out_kind    = KIND_VENDOR;
        r.in_header   = 1'b0;
        r.end_status  = END_NONE;
        r.payload_len = '0;
        case (phase)
            PH_HEADER: begin
                hsize = (pkt == PKT_EVENT) ? HDR_LEN_EVENT :
                        (pkt == PKT_ACL)   ? HDR_LEN_ACL   : HDR_LEN_SCO;
                r.out_kind  = {1'b0, pkt};
                r.in_header = 1'b1;
                if (hdr_idx == hsize - 3'd2) len_lo = b;
                hdr_idx = hdr_idx + 3'd1;
                if (hdr_idx >= hsize) begin
                    len = (pkt == PKT_ACL) ? {b, len_lo} : {8'h00, b};
                    r.payload_len = len;
                    hdr_idx = '0;
                    if (len == 16'd0) begin
                        r.end_status = good_end();
                        phase = PH_WAIT_TYPE;
                    end else if (len > cfg.max_payload_len) begin
                        // oversize: drop and hunt for the next type byte
                        r.end_status = END_DROP;
                        phase = PH_WAIT_TYPE;
                    end else begin
                        bytes_left = len;
                        phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.out_kind = {1'b0, pkt};
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    r.end_status = good_end();
                    phase = PH_WAIT_TYPE;
                end
            end
            default: begin
                phase = PH_WAIT_TYPE;
                if (b == TYPE_EVENT || b == TYPE_ACL || b == TYPE_SCO) begin
                    r.out_kind = KIND_TYPE;
                    pkt = (b == TYPE_EVENT) ? PKT_EVENT : (b == TYPE_ACL) ? PKT_ACL : PKT_SCO;
                    hdr_idx = '0;
                    len_lo = '0;
                    phase = PH_HEADER;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : p_score
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg.max_payload_len = MAX_PAYLOAD_LEN_RST;
            cfg.sco_deliver     = 1'b1;
            phase      = PH_WAIT_TYPE;
            pkt        = PKT_NONE;
            hdr_idx    = '0;
            len_lo     = '0;
            bytes_left = '0;
            tagged_byte_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_PAYLOAD_LEN: cfg.max_payload_len = i_cfg_data;
                    REG_SCO_DELIVER:     cfg.sco_deliver = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) tagged_byte_q.push_back(deframe_byte(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.out_byte    = i_m_tdata[7:0];
                got.end_status  = i_m_tdata[9:8];
                got.payload_len = i_m_tdata[25:10];
                got.out_kind    = i_m_tuser[2:0];
                got.in_header   = i_m_tuser[3];
                if (tagged_byte_q.size() == 0) begin
                    report_mismatch("unexpected item, byte", 32'(got.out_byte), 0);
                end else begin
                    want = tagged_byte_q.pop_front();
                    if (got.out_byte != want.out_byte)
                        report_mismatch("out_byte", 32'(got.out_byte),
                                        32'(want.out_byte));
                    if (got.out_kind != want.out_kind)
                        report_mismatch("out_kind", 32'(got.out_kind),
                                        32'(want.out_kind));
                    if (got.in_header != want.in_header)
                        report_mismatch("in_header", 32'(got.in_header),
                                        32'(want.in_header));
                    if (got.end_status != want.end_status)
                        report_mismatch("end_status", 32'(got.end_status),
                                        32'(want.end_status));
                    if (got.payload_len != want.payload_len)
                        report_mismatch("payload_len", 32'(got.payload_len),
                                        32'(want.payload_len));
                end
                result_no++;
            end
        end
        o_pending <= tagged_byte_q.size();
    end

endmodule

[bench/hci_h4_uart_deframer_tb.sv]
// Testbench top for the H4 deframer: clock, reset, byte stimulus, sink and verdict.
module hci_h4_uart_deframer_tb;
    import h4df_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int LONG_HOLD_AT = 300;
    localparam int PHASE_BYTES  = 350;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [15:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic [3:0]           m_axis_tuser;

    int          chk_mismatches;
    int          chk_pending;
    int          bytes_sent  = 0;
    int          bytes_taken = 0;
    int          idle_cycles = 0;
    logic [15:0] cur_max     = MAX_PAYLOAD_LEN_RST;
    logic [7:0]  directed_bytes [0:24];

    always #2 i_clk = ~i_clk;

    hci_h4_uart_deframer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hci_h4_uart_deframer_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_mismatches (chk_mismatches),
        .o_pending    (chk_pending)
    );

    // Runs of back-to-back items between stretches of random waits.
    function automatic int draw_wait(input int n);
        return ((n % 64) < 12) ? 0 : int'($urandom_range(0, 18));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(bytes_sent);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drain the block before touching a register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_packet(input int unsigned max_len);
        int unsigned pick;
        int unsigned len;
        logic [1:0]  kind;
        // noise byte between packets
        if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(0, 255)));
            return;
        end
        kind = 2'($urandom_range(PKT_EVENT, PKT_SCO));
        pick = $urandom_range(0, 10);
        if (pick < 2)       len = 0;
        else if (pick < 7)  len = $urandom_range(1, 24);
        else if (pick == 7) len = max_len;
        else if (pick == 8) len = max_len + 1;
        else if (pick == 9) len = (kind == PKT_ACL) ? $urandom_range(256, 320)
                                                    : $urandom_range(0, 255);
        else                len = $urandom_range(0, 65535);
        len = (kind == PKT_ACL) ? (len & 32'hFFFF) : (len & 32'hFF);
        // keep accepted payloads short
        if (len > 320 && len <= max_len) len = len % 24 + 1;
        case (kind)
            PKT_EVENT: begin
                send_byte(TYPE_EVENT);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(len[7:0]);
            end
            PKT_ACL: begin
                send_byte(TYPE_ACL);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(len[7:0]);
                send_byte(len[15:8]);
            end
            default: begin
                send_byte(TYPE_SCO);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(len[7:0]);
            end
        endcase
        if (len <= max_len) repeat (len) send_byte(8'($urandom_range(0, 255)));
        else repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int n);
        int stop;
        stop = bytes_sent + n;
        while (bytes_sent < stop) send_packet(32'(cur_max));
    endtask

    initial begin : p_stim
        directed_bytes = '{TYPE_EVENT, 8'h0E, 8'h00,
                           TYPE_EVENT, 8'h0E, 8'h02, 8'hAA, 8'h55,
                           8'hFF, 8'h00,
                           TYPE_ACL, 8'h01, 8'h20, 8'hFF, 8'hFF,
                           TYPE_SCO, 8'h01, 8'h00, 8'h01, 8'h80,
                           TYPE_ACL, 8'h00, 8'h00, 8'h00, 8'h00};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        run_random(PHASE_BYTES);

        // reject every payload, discard SCO
        cur_max = 16'd0;
        write_reg(REG_MAX_PAYLOAD_LEN, cur_max);
        write_reg(REG_SCO_DELIVER, {15'($urandom), 1'b0});
        run_random(PHASE_BYTES);

        cur_max = 16'hFFFF;
        write_reg(REG_MAX_PAYLOAD_LEN, cur_max);
        write_reg(REG_SCO_DELIVER, {15'($urandom), 1'b1});
        // unmapped indexes must be ignored
        write_reg(CFG_IDX_W'(2), 16'($urandom_range(0, 65535)));
        write_reg('1, 16'($urandom_range(0, 65535)));
        run_random(PHASE_BYTES);

        cur_max = 16'($urandom_range(1, 40));
        write_reg(REG_MAX_PAYLOAD_LEN, cur_max);
        write_reg(REG_SCO_DELIVER, 16'($urandom_range(0, 65535)));
        run_random(PHASE_BYTES);

        cur_max = 16'($urandom_range(0, 65535));
        write_reg(REG_MAX_PAYLOAD_LEN, cur_max);
        write_reg(REG_SCO_DELIVER, {15'($urandom), 1'b0});
        run_random(PHASE_BYTES);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (chk_mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : p_sink
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_wait(bytes_taken);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            bytes_taken++;
            // hold off long enough to back up the input side
            if (bytes_taken == LONG_HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

[files.f]
rtl/core/h4df_pkg.sv
rtl/core/h4df_parser.sv
rtl/core/hci_h4_uart_deframer.sv
bench/hci_h4_uart_deframer_chk.sv
bench/hci_h4_uart_deframer_tb.sv
